FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ccpt_pkg.sv
// ----------------------------------------------------------------------------
// ccpt_pkg
// Types, widths and helpers of the in-circumcircle point test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccpt_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int TOLW  = 16;          // flat tolerance width
    localparam int NUMW  = 100;         // signed numerator width
    localparam int DENW  = 68;          // signed denominator width
    localparam int QB    = 34;          // quotient bits computed
    localparam int RW    = DENW + QB;   // divider remainder width
    localparam int SQB   = 35;          // square root result bits
    localparam int RSW   = 66;          // squared distance width
    localparam int SRW   = 72;          // square root trial width
    localparam logic [TOLW-1:0] TOL_RESET = 16'd1;

    typedef struct packed {
        logic signed [CW-1:0] test_x;
        logic signed [CW-1:0] test_y;
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
    } in_t;

    typedef struct packed {
        logic                 inside_res;
        logic                 degenerate;
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic        [CW-1:0] radius;
    } out_t;

    // Data that rides alongside the division.
    typedef struct packed {
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] mid1;
        logic signed [CW-1:0] mid2;
        logic                 flat1;
        logic                 flat2;
        logic                 degen;
    } side_t;

    typedef struct packed {
        logic signed [NUMW-1:0] num;
        logic signed [DENW-1:0] den;
    } divreq_t;

    function automatic logic signed [CW:0] sub33(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        sub33 = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic signed [CW:0] add33(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        add33 = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ccpt_front.sv
// ----------------------------------------------------------------------------
// ccpt_front
// Seven-stage front end: differences, products, sums and divider operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccpt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  ccpt_pkg::in_t                 in_data,
    input  logic [ccpt_pkg::TOLW-1:0]     tol,
    output logic                          out_valid,
    output ccpt_pkg::divreq_t             req_x,
    output ccpt_pkg::divreq_t             req_y,
    output ccpt_pkg::side_t               side_out
);
    import ccpt_pkg::*;

    logic [7:1] v_reg;

    // Stage 1
    in_t               in1_reg;
    logic signed [CW:0] d_ab_y_reg, d_bc_y_reg, d_ca_y_reg;
    logic signed [CW:0] d_cb_x_reg, d_ac_x_reg, d_ba_x_reg;
    logic signed [CW:0] s_bc_y_reg, s_ab_y_reg, d_cb_y_reg, d_ba_y_reg;
    logic signed [CW:0] sx_ab_reg, sx_bc_reg;

    // Stage 2
    side_t               side2_reg;
    logic signed [64:0]  pd_reg [3];
    logic signed [63:0]  sq_reg [6];
    logic signed [65:0]  f1a_reg, f1b_reg, f2a_reg, f2b_reg;
    logic signed [CW:0]  dv2_reg [6];
    logic signed [CW:0]  dcb2_reg, dba2_reg;
    logic [CW:0]         abs_ab, abs_bc;
    logic signed [CW:0]  mr1, mr2;

    // Stage 3
    side_t               side3_reg;
    logic signed [DENW-1:0] dd3_reg;
    logic [63:0]         s3_reg [3];
    logic signed [66:0]  num1_3_reg, num2_3_reg;
    logic signed [33:0]  den1_3_reg, den2_3_reg;
    logic signed [CW:0]  dv3_reg [6];
    logic signed [DENW-1:0] dsum;

    // Stage 4
    side_t               side4_reg;
    logic signed [DENW-1:0] dd4_reg;
    logic                dz4_reg;
    logic signed [66:0]  num1_4_reg, num2_4_reg;
    logic signed [33:0]  den1_4_reg, den2_4_reg;
    logic signed [65:0]  pl_reg [6];
    logic signed [65:0]  ph_reg [6];

    // Stage 5
    side_t               side5_reg;
    logic signed [DENW-1:0] dd5_reg;
    logic                dz5_reg;
    logic signed [66:0]  num1_5_reg, num2_5_reg;
    logic signed [33:0]  den1_5_reg, den2_5_reg;
    logic signed [NUMW-1:0] t_reg [6];

    // Stage 6
    side_t               side6_reg;
    logic signed [DENW-1:0] dd6_reg;
    logic                dz6_reg;
    logic signed [66:0]  num1_6_reg, num2_6_reg;
    logic signed [33:0]  den1_6_reg, den2_6_reg;
    logic signed [NUMW-1:0] nx_reg, ny_reg;

    // Stage 7
    side_t               side7_reg, side7_next;
    divreq_t             reqx_reg, reqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:1], in_valid};
        end
    end

    assign abs_ab = d_ab_y_reg[CW] ? $unsigned(-d_ab_y_reg) : $unsigned(d_ab_y_reg);
    assign abs_bc = d_bc_y_reg[CW] ? $unsigned(-d_bc_y_reg) : $unsigned(d_bc_y_reg);
    // Halving rounds toward zero: add one to a negative sum before the shift.
    assign mr1 = sx_ab_reg + $signed({{CW{1'b0}}, sx_ab_reg[CW]});
    assign mr2 = sx_bc_reg + $signed({{CW{1'b0}}, sx_bc_reg[CW]});
    assign dsum = DENW'(pd_reg[0]) + DENW'(pd_reg[1]) + DENW'(pd_reg[2]);

    // Mark the cases with no circle.
    always_comb begin
        side7_next       = side6_reg;
        side7_next.degen = (side6_reg.flat1 && side6_reg.flat2)
                        || (!side6_reg.flat1 && !side6_reg.flat2 && dz6_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1
            in1_reg    <= in_data;
            d_ab_y_reg <= sub33(in_data.vert_a_y, in_data.vert_b_y);
            d_bc_y_reg <= sub33(in_data.vert_b_y, in_data.vert_c_y);
            d_ca_y_reg <= sub33(in_data.vert_c_y, in_data.vert_a_y);
            d_cb_x_reg <= sub33(in_data.vert_c_x, in_data.vert_b_x);
            d_ac_x_reg <= sub33(in_data.vert_a_x, in_data.vert_c_x);
            d_ba_x_reg <= sub33(in_data.vert_b_x, in_data.vert_a_x);
            s_bc_y_reg <= add33(in_data.vert_b_y, in_data.vert_c_y);
            s_ab_y_reg <= add33(in_data.vert_a_y, in_data.vert_b_y);
            d_cb_y_reg <= sub33(in_data.vert_c_y, in_data.vert_b_y);
            d_ba_y_reg <= sub33(in_data.vert_b_y, in_data.vert_a_y);
            sx_ab_reg  <= add33(in_data.vert_a_x, in_data.vert_b_x);
            sx_bc_reg  <= add33(in_data.vert_c_x, in_data.vert_b_x);

            // Stage 2
            side2_reg.bx    <= in1_reg.vert_b_x;
            side2_reg.by    <= in1_reg.vert_b_y;
            side2_reg.px    <= in1_reg.test_x;
            side2_reg.py    <= in1_reg.test_y;
            side2_reg.mid1  <= mr1[CW:1];
            side2_reg.mid2  <= mr2[CW:1];
            side2_reg.flat1 <= abs_ab < (CW+1)'(tol);
            side2_reg.flat2 <= abs_bc < (CW+1)'(tol);
            side2_reg.degen <= 1'b0;
            pd_reg[0] <= in1_reg.vert_a_x * d_bc_y_reg;
            pd_reg[1] <= in1_reg.vert_b_x * d_ca_y_reg;
            pd_reg[2] <= in1_reg.vert_c_x * d_ab_y_reg;
            sq_reg[0] <= in1_reg.vert_a_x * in1_reg.vert_a_x;
            sq_reg[1] <= in1_reg.vert_a_y * in1_reg.vert_a_y;
            sq_reg[2] <= in1_reg.vert_b_x * in1_reg.vert_b_x;
            sq_reg[3] <= in1_reg.vert_b_y * in1_reg.vert_b_y;
            sq_reg[4] <= in1_reg.vert_c_x * in1_reg.vert_c_x;
            sq_reg[5] <= in1_reg.vert_c_y * in1_reg.vert_c_y;
            f1a_reg <= s_bc_y_reg * d_cb_y_reg;
            f1b_reg <= d_cb_x_reg * d_ac_x_reg;
            f2a_reg <= s_ab_y_reg * d_ba_y_reg;
            f2b_reg <= d_ba_x_reg * d_ac_x_reg;
            dv2_reg[0] <= d_bc_y_reg;
            dv2_reg[1] <= d_ca_y_reg;
            dv2_reg[2] <= d_ab_y_reg;
            dv2_reg[3] <= d_cb_x_reg;
            dv2_reg[4] <= d_ac_x_reg;
            dv2_reg[5] <= d_ba_x_reg;
            dcb2_reg <= d_cb_y_reg;
            dba2_reg <= d_ba_y_reg;

            // Stage 3
            side3_reg <= side2_reg;
            dd3_reg   <= dsum <<< 1;
            s3_reg[0] <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]);
            s3_reg[1] <= $unsigned(sq_reg[2]) + $unsigned(sq_reg[3]);
            s3_reg[2] <= $unsigned(sq_reg[4]) + $unsigned(sq_reg[5]);
            num1_3_reg <= 67'(f1a_reg) - 67'(f1b_reg);
            // Second flat case uses (Cx-Ax) = -(Ax-Cx).
            num2_3_reg <= 67'(f2a_reg) + 67'(f2b_reg);
            den1_3_reg <= $signed({dcb2_reg, 1'b0});
            den2_3_reg <= $signed({dba2_reg, 1'b0});
            dv3_reg    <= dv2_reg;

            // Stage 4: each 64-bit sum of squares times a difference in two halves.
            side4_reg  <= side3_reg;
            dd4_reg    <= dd3_reg;
            dz4_reg    <= (dd3_reg == '0);
            num1_4_reg <= num1_3_reg;
            num2_4_reg <= num2_3_reg;
            den1_4_reg <= den1_3_reg;
            den2_4_reg <= den2_3_reg;
            for (int j = 0; j < 6; j++) begin
                pl_reg[j] <= $signed({1'b0, s3_reg[j % 3][31:0]}) * dv3_reg[j];
                ph_reg[j] <= $signed({1'b0, s3_reg[j % 3][63:32]}) * dv3_reg[j];
            end

            // Stage 5
            side5_reg  <= side4_reg;
            dd5_reg    <= dd4_reg;
            dz5_reg    <= dz4_reg;
            num1_5_reg <= num1_4_reg;
            num2_5_reg <= num2_4_reg;
            den1_5_reg <= den1_4_reg;
            den2_5_reg <= den2_4_reg;
            for (int j = 0; j < 6; j++) begin
                t_reg[j] <= (NUMW'(ph_reg[j]) <<< 32) + NUMW'(pl_reg[j]);
            end

            // Stage 6
            side6_reg  <= side5_reg;
            dd6_reg    <= dd5_reg;
            dz6_reg    <= dz5_reg;
            num1_6_reg <= num1_5_reg;
            num2_6_reg <= num2_5_reg;
            den1_6_reg <= den1_5_reg;
            den2_6_reg <= den2_5_reg;
            nx_reg <= t_reg[0] + t_reg[1] + t_reg[2];
            ny_reg <= t_reg[3] + t_reg[4] + t_reg[5];

            // Stage 7: choose the y quotient.
            side7_reg    <= side7_next;
            reqx_reg.num <= nx_reg;
            reqx_reg.den <= dd6_reg;
            if (side6_reg.flat1) begin
                reqy_reg.num <= NUMW'(num1_6_reg);
                reqy_reg.den <= DENW'(den1_6_reg);
            end else if (side6_reg.flat2) begin
                reqy_reg.num <= NUMW'(num2_6_reg);
                reqy_reg.den <= DENW'(den2_6_reg);
            end else begin
                reqy_reg.num <= ny_reg;
                reqy_reg.den <= dd6_reg;
            end
        end
    end

    assign out_valid = v_reg[7];
    assign req_x     = reqx_reg;
    assign req_y     = reqy_reg;
    assign side_out  = side7_reg;

endmodule

`default_nettype wire

FILE: rtl/ccpt_div.sv
// ----------------------------------------------------------------------------
// ccpt_div
// Two-lane pipelined restoring divider, signed, saturated to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccpt_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  ccpt_pkg::divreq_t         req_x,
    input  ccpt_pkg::divreq_t         req_y,
    input  ccpt_pkg::side_t           side_in,
    output logic                      out_valid,
    output logic signed [ccpt_pkg::CW-1:0] q_x,
    output logic signed [ccpt_pkg::CW-1:0] q_y,
    output ccpt_pkg::side_t           side_out
);
    import ccpt_pkg::*;

    localparam int NST = QB + 3;

    logic [NST-1:0]        v_reg;
    side_t                 side_reg [NST];
    divreq_t               req [2];
    logic signed [CW-1:0]  q_res [2];

    assign req[0] = req_x;
    assign req[1] = req_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int s = 1; s < NST; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [NUMW-1:0]  nmag;
        logic [DENW-1:0]  dmag;
        logic [NUMW-1:0]  nabs0_reg;
        logic [DENW-1:0]  dabs0_reg;
        logic             neg0_reg;
        logic [RW-1:0]    rem_reg [QB];
        logic [DENW-1:0]  den_reg [QB];
        logic [QB-1:0]    q_reg   [QB+1];
        logic             sat_reg [QB+1];
        logic             neg_reg [QB+1];
        logic signed [CW-1:0] qo_reg;

        assign nmag = req[l].num[NUMW-1] ? (~req[l].num + 1'b1) : req[l].num;
        assign dmag = req[l].den[DENW-1] ? (~req[l].den + 1'b1) : req[l].den;

        always_ff @(posedge aclk) begin
            if (en) begin
                nabs0_reg <= nmag;
                dabs0_reg <= dmag;
                neg0_reg  <= req[l].num[NUMW-1] ^ req[l].den[DENW-1];
                // A quotient of 2^QB or more saturates whatever its sign.
                rem_reg[0] <= RW'(nabs0_reg);
                den_reg[0] <= dabs0_reg;
                sat_reg[0] <= RW'(nabs0_reg) >= {dabs0_reg, {QB{1'b0}}};
                q_reg[0]   <= '0;
                neg_reg[0] <= neg0_reg;
            end
        end

        for (genvar k = 0; k < QB; k++) begin : g_it
            localparam int B = QB - 1 - k;
            logic [RW-1:0] trial;
            logic          ge;
            logic [QB-1:0] qn;

            assign trial = RW'(den_reg[k]) << B;
            assign ge    = rem_reg[k] >= trial;
            always_comb begin
                qn    = q_reg[k];
                qn[B] = ge;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k+1]   <= qn;
                    sat_reg[k+1] <= sat_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                end
            end

            if (k < QB - 1) begin : g_rem
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k+1] <= ge ? (rem_reg[k] - trial) : rem_reg[k];
                        den_reg[k+1] <= den_reg[k];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (neg_reg[QB]) begin
                    if (sat_reg[QB] || q_reg[QB] > QB'(33'h080000000)) begin
                        qo_reg <= $signed(32'h80000000);
                    end else begin
                        qo_reg <= -$signed(q_reg[QB][CW-1:0]);
                    end
                end else begin
                    if (sat_reg[QB] || q_reg[QB] > QB'(33'h07FFFFFFF)) begin
                        qo_reg <= $signed(32'h7FFFFFFF);
                    end else begin
                        qo_reg <= $signed(q_reg[QB][CW-1:0]);
                    end
                end
            end
        end

        assign q_res[l] = qo_reg;
    end

    assign out_valid = v_reg[NST-1];
    assign side_out  = side_reg[NST-1];
    assign q_x       = q_res[0];
    assign q_y       = q_res[1];

endmodule

`default_nettype wire

FILE: rtl/ccpt_back.sv
// ----------------------------------------------------------------------------
// ccpt_back
// Centre selection, squared distances, comparison and pipelined square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccpt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ccpt_pkg::CW-1:0] q_x,
    input  logic signed [ccpt_pkg::CW-1:0] q_y,
    input  ccpt_pkg::side_t               side_in,
    output logic                          out_valid,
    output ccpt_pkg::out_t                out_data
);
    import ccpt_pkg::*;

    localparam int NST = SQB + 3;

    logic [NST-1:0]       v_reg;
    logic signed [CW-1:0] cx_sel;

    // Stage 1
    logic signed [CW-1:0] cx1_reg, cy1_reg;
    logic signed [CW:0]   dxb_reg, dyb_reg, dxp_reg, dyp_reg;
    logic                 dg1_reg;

    // Stage 2
    logic signed [CW-1:0] cx2_reg, cy2_reg;
    logic [RSW-2:0]       qbx_reg, qby_reg, qpx_reg, qpy_reg;
    logic                 dg2_reg;
    logic signed [65:0]   pbx, pby, ppx, ppy;
    logic [RSW-1:0]       rs_sum, ds_sum;

    // Square root pipeline, entry 0 is filled by the sum stage.
    logic [RSW-1:0]       r_reg    [SQB];
    logic [SQB-1:0]       root_reg [SQB+1];
    logic                 ins_reg  [SQB+1];
    logic signed [CW-1:0] cx_reg   [SQB+1];
    logic signed [CW-1:0] cy_reg   [SQB+1];
    logic                 dg_reg   [SQB+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    assign cx_sel = side_in.flat1 ? side_in.mid1 : (side_in.flat2 ? side_in.mid2 : q_x);
    assign pbx = dxb_reg * dxb_reg;
    assign pby = dyb_reg * dyb_reg;
    assign ppx = dxp_reg * dxp_reg;
    assign ppy = dyp_reg * dyp_reg;
    assign rs_sum = RSW'(qbx_reg) + RSW'(qby_reg);
    assign ds_sum = RSW'(qpx_reg) + RSW'(qpy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            cx1_reg <= cx_sel;
            cy1_reg <= q_y;
            dxb_reg <= sub33(side_in.bx, cx_sel);
            dyb_reg <= sub33(side_in.by, q_y);
            dxp_reg <= sub33(side_in.px, cx_sel);
            dyp_reg <= sub33(side_in.py, q_y);
            dg1_reg <= side_in.degen;

            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            qbx_reg <= pbx[RSW-2:0];
            qby_reg <= pby[RSW-2:0];
            qpx_reg <= ppx[RSW-2:0];
            qpy_reg <= ppy[RSW-2:0];
            dg2_reg <= dg1_reg;

            r_reg[0]    <= rs_sum;
            root_reg[0] <= '0;
            ins_reg[0]  <= ds_sum <= rs_sum;
            cx_reg[0]   <= cx2_reg;
            cy_reg[0]   <= cy2_reg;
            dg_reg[0]   <= dg2_reg;
        end
    end

    for (genvar k = 0; k < SQB; k++) begin : g_sq
        localparam int B = SQB - 1 - k;
        logic [SRW-1:0] trial;
        logic           ge;
        logic [SQB-1:0] rn;

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial = (SRW'(root_reg[k]) << (B + 1)) + (SRW'(1) << (2 * B));
        assign ge    = SRW'(r_reg[k]) >= trial;
        always_comb begin
            rn    = root_reg[k];
            rn[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k+1] <= rn;
                ins_reg[k+1]  <= ins_reg[k];
                cx_reg[k+1]   <= cx_reg[k];
                cy_reg[k+1]   <= cy_reg[k];
                dg_reg[k+1]   <= dg_reg[k];
            end
        end

        if (k < SQB - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k+1] <= ge ? (r_reg[k] - trial[RSW-1:0]) : r_reg[k];
                end
            end
        end
    end

    always_comb begin
        out_data = '0;
        if (dg_reg[SQB]) begin
            out_data.degenerate = 1'b1;
        end else begin
            out_data.inside_res = ins_reg[SQB];
            out_data.centre_x   = cx_reg[SQB];
            out_data.centre_y   = cy_reg[SQB];
            out_data.radius     = (root_reg[SQB][SQB-1:CW] != '0) ? '1
                                                               : root_reg[SQB][CW-1:0];
        end
    end

    assign out_valid = v_reg[NST-1];

endmodule

`default_nettype wire

FILE: rtl/circumcircle_point_test.sv
// Throughput: one request per cycle while the output is not stalled; the 34-step divider
// and the 35-step square root are fully pipelined, one quotient or root bit per stage.
// Reset: aresetn is synchronous and active low; it empties the pipeline and sets
// the flat tolerance register to one raw count.
// ----------------------------------------------------------------------------
// circumcircle_point_test
// Fixed-point Delaunay in-circumcircle test with centre and radius output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circumcircle_point_test (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: the flat tolerance register.
    input  logic                        cfg_we,
    input  logic [ccpt_pkg::TOLW-1:0]   cfg_wdata,
    // Request channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ccpt_pkg::in_t               s_data,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output ccpt_pkg::out_t              m_data
);
    import ccpt_pkg::*;

    // The whole pipeline moves as one. It advances whenever the output
    // register is empty or its result is being taken, so requests keep
    // streaming in while earlier ones are still in flight.
    logic                 en;
    logic [TOLW-1:0]      tol_reg;

    logic                 f_valid;
    divreq_t              f_req_x, f_req_y;
    side_t                f_side;

    logic                 d_valid;
    logic signed [CW-1:0] d_qx, d_qy;
    side_t                d_side;

    logic                 b_valid;
    out_t                 b_data;

    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // Front end: edge differences, products and divider operands.
    ccpt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .req_x     (f_req_x),
        .req_y     (f_req_y),
        .side_out  (f_side)
    );

    // Both centre coordinates are divided side by side.
    ccpt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .req_x     (f_req_x),
        .req_y     (f_req_y),
        .side_in   (f_side),
        .out_valid (d_valid),
        .q_x       (d_qx),
        .q_y       (d_qy),
        .side_out  (d_side)
    );

    // Back end: distances from the saturated centre, compare, radius.
    ccpt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .q_x       (d_qx),
        .q_y       (d_qy),
        .side_in   (d_side),
        .out_valid (b_valid),
        .out_data  (b_data)
    );

    // Output register: holds a finished result until the consumer takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (en) begin
            m_valid_next = b_valid;
            m_data_next  = b_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/ccpt_checker.sv
// ----------------------------------------------------------------------------
// ccpt_assert
// Port-level checks of the in-circumcircle point test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ccpt_assert (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_ready,
    input  logic           m_valid,
    input  logic           m_ready,
    input  ccpt_pkg::out_t m_data
);
    import ccpt_pkg::*;

    logic degen_clear;

    // A degenerate result carries nothing else.
    assign degen_clear = !m_data.inside_res && m_data.centre_x == 0
                      && m_data.centre_y == 0 && m_data.radius == 0;

    `ASSERT_RST(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `ASSERT_RST(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result changed")
    `ASSERT_RST(a_degen_zero, aclk, aresetn, m_valid && m_data.degenerate |-> degen_clear, "degenerate result not cleared")
    `ASSERT_RST(a_ready, aclk, aresetn, s_ready == (!m_valid || m_ready), "request side stalled")
    `ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind circumcircle_point_test ccpt_assert u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: bench/ccpt_checker.sv
// ----------------------------------------------------------------------------
// ccpt_checker
// Watches the request and result channels of the circumcircle point test,
// works out the expected result of every accepted request and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccpt_checker
    import ccpt_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [TOLW-1:0] cfg_wdata,
    input  logic            s_valid,
    input  logic            s_ready,
    input  in_t             s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  out_t            m_data,
    output int              error_count,
    output int              pending_count
);

    typedef logic signed [199:0] big_t;

    localparam big_t S32_MAX = 200'sd2147483647;
    localparam big_t S32_MIN = -200'sd2147483648;

    logic [TOLW-1:0] tolerance;
    out_t            circle_queue[$];

    function automatic big_t quot_sat(big_t n, big_t d);
        big_t q;
        q = n / d;
        if (q > S32_MAX) q = S32_MAX;
        if (q < S32_MIN) q = S32_MIN;
        return q;
    endfunction

    function automatic big_t dist_sq(big_t x, big_t y, big_t cx, big_t cy);
        return (x - cx) * (x - cx) + (y - cy) * (y - cy);
    endfunction

    function automatic out_t predict_circle(in_t r, logic [TOLW-1:0] tol);
        big_t px, py, ax, ay, bx, by, qx, qy, t, cx, cy, d, sa, sb, sc, rs, ds, root, cand;
        logic  flat1, flat2;
        out_t  o;
        px = r.test_x;   py = r.test_y;
        ax = r.vert_a_x; ay = r.vert_a_y;
        bx = r.vert_b_x; by = r.vert_b_y;
        qx = r.vert_c_x; qy = r.vert_c_y;
        t  = $signed({1'b0, tol});
        o  = '0;
        flat1 = ((ay - by) < 0 ? by - ay : ay - by) < t;
        flat2 = ((by - qy) < 0 ? qy - by : by - qy) < t;
        if (flat1 && flat2) begin
            o.degenerate = 1'b1;
            return o;
        end
        if (flat1) begin
            cx = (ax + bx) / 2;
            cy = quot_sat((by + qy) * (qy - by) - (qx - bx) * (ax - qx), 2 * (qy - by));
        end else if (flat2) begin
            cx = (qx + bx) / 2;
            cy = quot_sat((ay + by) * (by - ay) - (bx - ax) * (qx - ax), 2 * (by - ay));
        end else begin
            d = 2 * (ax * (by - qy) + bx * (qy - ay) + qx * (ay - by));
            if (d == 0) begin
                o.degenerate = 1'b1;
                return o;
            end
            sa = ax * ax + ay * ay;
            sb = bx * bx + by * by;
            sc = qx * qx + qy * qy;
            cx = quot_sat(sa * (by - qy) + sb * (qy - ay) + sc * (ay - by), d);
            cy = quot_sat(sa * (qx - bx) + sb * (ax - qx) + sc * (bx - ax), d);
        end
        rs = dist_sq(bx, by, cx, cy);
        ds = dist_sq(px, py, cx, cy);
        root = 0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (big_t'(1) <<< b);
            if (cand * cand <= rs) root = cand;
        end
        o.inside_res = (ds <= rs);
        o.centre_x   = cx[CW-1:0];
        o.centre_y   = cy[CW-1:0];
        o.radius     = (root > 200'sd4294967295) ? 32'hFFFF_FFFF : root[CW-1:0];
        return o;
    endfunction

    assign pending_count = circle_queue.size();

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            tolerance   <= TOL_RESET;
            error_count <= 0;
            circle_queue.delete();
        end else begin
            if (s_valid && s_ready) circle_queue.push_back(predict_circle(s_data, tolerance));
            if (m_valid && m_ready) begin
                if (circle_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    error_count <= error_count + 1;
                end else begin
                    want = circle_queue.pop_front();
                    if (want.inside_res !== m_data.inside_res ||
                        want.degenerate !== m_data.degenerate ||
                        want.centre_x !== m_data.centre_x ||
                        want.centre_y !== m_data.centre_y ||
                        want.radius !== m_data.radius) begin
                        $display("%0t: mismatch expected in=%b deg=%b cx=%h cy=%h r=%h",
                                 $time, want.inside_res, want.degenerate, want.centre_x,
                                 want.centre_y, want.radius);
                        $display("%0t:          actual   in=%b deg=%b cx=%h cy=%h r=%h",
                                 $time, m_data.inside_res, m_data.degenerate,
                                 m_data.centre_x, m_data.centre_y, m_data.radius);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (cfg_we) tolerance <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives requests, tolerance writes and result backpressure into the
// circumcircle point test; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import ccpt_pkg::*;

    localparam int LATENCY    = 82;
    localparam int STALL_MAX  = 3000;
    localparam int RAND_ITEMS = 1050;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_we = 1'b0;
    logic [TOLW-1:0] cfg_wdata = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_t             s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_t            m_data;
    int              error_count;
    int              pending_count;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              quiet_cycles = 0;

    always #5 aclk = ~aclk;

    circumcircle_point_test u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    ccpt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too many cycles in a row with no request and no result moving
    // means the block has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, with random idle cycles in front of it, and returns
    // at the edge that accepts it. The next call then changes valid and data
    // in the same step, which is a single assignment per signal.
    task automatic send_request(input in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic in_t make_triangle(
        input int px, input int py, input int ax, input int ay,
        input int bx, input int by, input int cx, input int cy);
        in_t r;
        r.test_x = px;   r.test_y = py;
        r.vert_a_x = ax; r.vert_a_y = ay;
        r.vert_b_x = bx; r.vert_b_y = by;
        r.vert_c_x = cx; r.vert_c_y = cy;
        return r;
    endfunction

    // Coordinate of a chosen magnitude: mostly moderate values so that the
    // test point falls inside often, sometimes anything at all.
    function automatic int rand_coord(input int span);
        if (span >= 31) return int'($urandom);
        return int'($urandom_range(2 ** span)) - 2 ** (span - 1);
    endfunction

    function automatic in_t random_triangle(input logic [TOLW-1:0] tol);
        in_t r;
        int  span;
        int  kind;
        kind = $urandom_range(9);
        span = (kind == 0) ? 31 : $urandom_range(24, 4);
        r = make_triangle(rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span));
        case (kind)
            1: begin
                // Edge AB within the tolerance of flat.
                r.vert_a_y = r.vert_b_y + int'($urandom_range(tol)) - int'(tol / 2);
            end
            2: begin
                // Edge BC within the tolerance of flat.
                r.vert_c_y = r.vert_b_y + int'($urandom_range(tol)) - int'(tol / 2);
            end
            3: begin
                // Vertices on one horizontal line, or edge AB flat with C off it.
                r.vert_a_y = r.vert_b_y;
                r.vert_c_y = r.vert_b_y + ($urandom_range(1) ? 0 : span);
            end
            4: begin
                // Test point taken from a vertex, so it lies on the circle.
                r.test_x = r.vert_c_x;
                r.test_y = r.vert_c_y;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_tolerance(input logic [TOLW-1:0] value);
        // The block must be empty before the register changes. The wait starts behind a clock
        // edge, so that the last accepted request is already counted.
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [TOLW-1:0] tol;
        logic [TOLW-1:0] tol_steps[4];
        int              per_phase;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset tolerance of one count.
        send_request(make_triangle(0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_triangle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                   32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_request(make_triangle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                   32'sh8000_0000, 32'sh8000_0000));
        send_request(make_triangle(-1, -1, -1, 0, 0, -1, -1, -1));
        // Flat edge AB, flat edge BC, and a triangle with no flat edge.
        send_request(make_triangle(65536, 65536, 0, 0, 131072, 0, 65536, 131072));
        send_request(make_triangle(65536, 65536, 65536, 131072, 0, 0, 131072, 0));
        send_request(make_triangle(3 << 16, 3 << 16, 0, 0, 4 << 16, 1 << 16,
                                   0, 3 << 16));
        // Point exactly on the circle and just outside it.
        send_request(make_triangle(0, 2 << 16, 2 << 16, 0, 0, -(2 << 16), -(2 << 16), 0));
        send_request(make_triangle(0, (2 << 16) + 1, 2 << 16, 0, 0, -(2 << 16),
                                   -(2 << 16), 0));
        // Collinear vertices, and a thin triangle whose centre saturates.
        send_request(make_triangle(5, 5, 0, 0, 65536, 65536, 131072, 131072));
        send_request(make_triangle(0, 0, 32'sh8000_0000, 0, 0, 1, 32'sh7FFF_FFFF, 3));
        send_request(make_triangle(0, 0, 32'sh7FFF_FFFF, 5, 32'sh8000_0000, 5, 0, 9));
        send_request(make_triangle(-7, 3, -3, -8, 5, 9, 0, 9));

        // Random requests: each tolerance setting runs through the three
        // idling patterns, sender-heavy, receiver-heavy and none.
        tol_steps = '{16'd1, 16'd0, 16'hFFFF, 16'd0};
        tol_steps[3] = 16'($urandom_range(2, 65534));
        per_phase = RAND_ITEMS / 12;
        foreach (tol_steps[i]) begin
            tol = tol_steps[i];
            s_valid <= 1'b0;
            write_tolerance(tol);
            for (int mode = 0; mode < 3; mode++) begin
                send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 57 : 0;
                recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 29 : 0;
                for (int n = 0; n < per_phase; n++) send_request(random_triangle(tol));
            end
        end
        s_valid <= 1'b0;

        // Let every result drain, then allow for the pipeline depth.
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/ccpt_pkg.sv
rtl/ccpt_front.sv
rtl/ccpt_div.sv
rtl/ccpt_back.sv
rtl/circumcircle_point_test.sv
rtl/ccpt_checker.sv
bench/ccpt_checker.sv
bench/tb.sv
